FILE: src/wtr_pkg.sv
package wtr_pkg;

	localparam int WAVELENGTH_BITS = 10;
	localparam int LUT_DEPTH       = 1024;

	localparam int NUM_CH   = 3;
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	localparam int Q15_W = 16;
	localparam logic [Q15_W-1:0] ONE_Q15 = 16'h8000;

	typedef logic [Q15_W-1:0] q15_t;
	typedef q15_t [NUM_CH-1:0] q15_vec_t;
	typedef logic [NUM_CH-1:0][7:0] pix_vec_t;

	// segment edges in nm
	localparam int WL_MIN = 380;
	localparam int WL_B1  = 440;
	localparam int WL_B2  = 490;
	localparam int WL_B3  = 510;
	localparam int WL_B4  = 580;
	localparam int WL_B5  = 645;
	localparam int WL_F1  = 420;
	localparam int WL_F2  = 700;
	localparam int WL_MAX = 780;

	// segment ramp tables
	localparam int TAB_DEPTH = 80;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);

	localparam int TAB_R1  = 0;
	localparam int TAB_G2  = 1;
	localparam int TAB_B3  = 2;
	localparam int TAB_R4  = 3;
	localparam int TAB_G5  = 4;
	localparam int TAB_FLO = 5;
	localparam int TAB_FHI = 6;

	localparam int DEN_R1  = 60;
	localparam int DEN_G2  = 50;
	localparam int DEN_B3  = 20;
	localparam int DEN_R4  = 70;
	localparam int DEN_G5  = 65;
	localparam int DEN_FLO = 400;
	localparam int DEN_FHI = 800;
	localparam int CNT_FLO = 40;
	localparam int CNT_FHI = 80;

	typedef q15_t seg_tab_t [TAB_DEPTH];

	function automatic q15_t seg_frac(int k, int sel);
		int q;
		q = 0;
		case (sel)
			TAB_R1:  if (k < DEN_R1) q = ((DEN_R1 - k) * 32768) / DEN_R1;
			TAB_G2:  if (k < DEN_G2) q = (k * 32768) / DEN_G2;
			TAB_B3:  if (k < DEN_B3) q = ((DEN_B3 - k) * 32768) / DEN_B3;
			TAB_R4:  if (k < DEN_R4) q = (k * 32768) / DEN_R4;
			TAB_G5:  if (k < DEN_G5) q = ((DEN_G5 - k) * 32768) / DEN_G5;
			TAB_FLO: if (k < CNT_FLO) q = ((120 + 7 * k) * 32768) / DEN_FLO;
			TAB_FHI: if (k < CNT_FHI) q = ((240 + 7 * (CNT_FHI - 1 - k)) * 32768) / DEN_FHI;
			default: q = 0;
		endcase
		return Q15_W'(q);
	endfunction

	function automatic seg_tab_t build_tab(int sel);
		seg_tab_t t;
		for (int k = 0; k < TAB_DEPTH; k++)
			t[k] = seg_frac(k, sel);
		return t;
	endfunction

	localparam seg_tab_t ROM_R1  = build_tab(TAB_R1);
	localparam seg_tab_t ROM_G2  = build_tab(TAB_G2);
	localparam seg_tab_t ROM_B3  = build_tab(TAB_B3);
	localparam seg_tab_t ROM_R4  = build_tab(TAB_R4);
	localparam seg_tab_t ROM_G5  = build_tab(TAB_G5);
	localparam seg_tab_t ROM_FLO = build_tab(TAB_FLO);
	localparam seg_tab_t ROM_FHI = build_tab(TAB_FHI);

	// gamma ROM, split in banks of 256
	localparam int IDX_W      = $clog2(LUT_DEPTH);
	localparam int BANK_AW    = 8;
	localparam int BANK_DEPTH = 2 ** BANK_AW;
	localparam int BSEL_W     = (IDX_W > BANK_AW) ? IDX_W - BANK_AW : 1;
	localparam int BANKS      = 2 ** BSEL_W;
	localparam int ROM_AW     = BANK_AW + BSEL_W;
	localparam int ROM_DEPTH  = BANKS * BANK_DEPTH;
	localparam logic [15:0] GAMMA_D = 16'(LUT_DEPTH - 1);

	typedef logic [NUM_CH-1:0][ROM_AW-1:0] idx_vec_t;
	typedef logic [7:0] gamma_rom_t [ROM_DEPTH];

	// largest y with y^5 * D^4 <= 255^5 * i^4
	function automatic logic [7:0] gamma_entry(int i);
		logic [127:0] d, d4, iv, i4, y, y5, rhs5;
		int lo, hi, mid;
		lo = 0;
		hi = 255;
		d  = 128'(GAMMA_D);
		d4 = d * d * d * d;
		iv = 128'(i);
		i4 = iv * iv * iv * iv;
		rhs5 = 128'(255) * 128'(255) * 128'(255) * 128'(255) * 128'(255);
		if (i == 0 || i > LUT_DEPTH - 1)
			return 8'd0;
		for (int s = 0; s < 9; s++) begin
			if (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				y   = 128'(mid);
				y5  = y * y * y * y * y;
				if (y5 * d4 <= rhs5 * i4)
					lo = mid;
				else
					hi = mid - 1;
			end
		end
		return 8'(lo);
	endfunction

	function automatic gamma_rom_t build_gamma();
		gamma_rom_t t;
		for (int i = 0; i < ROM_DEPTH; i++)
			t[i] = gamma_entry(i);
		return t;
	endfunction

	localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

FILE: src/wavelength_to_rgb_color_core.sv
// channel  direction  handshake               payload
// wave     in         wave_valid/wave_stall   wavelength_nm
// rgb      out        rgb_valid/rgb_stall     red, green, blue
//
// One item per clock when not stalled; rgb_valid rises once the item has passed the stages below.
// Stages: input reg, segment tables, color*factor multiply, index multiply,
// gamma bank read, bank select/output reg.
// Reset clears the stage valid bits; wave_stall is high while in reset.
// rgb_stall backs up only as far as the first empty stage; bubbles are
// filled.
module wavelength_to_rgb_color_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wave_valid,
	output logic                                wave_stall,
	input  logic [wtr_pkg::WAVELENGTH_BITS-1:0] wavelength_nm,
	output logic                                rgb_valid,
	input  logic                                rgb_stall,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic [wtr_pkg::WAVELENGTH_BITS-1:0] w_s1;
	wtr_pkg::q15_vec_t col_s2;
	wtr_pkg::q15_t     fac_s2;
	wtr_pkg::idx_vec_t idx_s4;
	wtr_pkg::pix_vec_t pix_s6;

	assign en6 = !vld_s6 || !rgb_stall;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign wave_stall = !arst_n || !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= wave_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1)
			w_s1 <= wavelength_nm;
	end

	wtr_spectrum u_spectrum (
		.clk    (clk),
		.en     (en2),
		.w_s1   (w_s1),
		.col_s2 (col_s2),
		.fac_s2 (fac_s2)
	);

	wtr_scale u_scale (
		.clk    (clk),
		.en3    (en3),
		.en4    (en4),
		.col_s2 (col_s2),
		.fac_s2 (fac_s2),
		.idx_s4 (idx_s4)
	);

	wtr_gamma u_gamma (
		.clk    (clk),
		.en5    (en5),
		.en6    (en6),
		.idx_s4 (idx_s4),
		.pix_s6 (pix_s6)
	);

	assign rgb_valid = vld_s6;
	assign red       = pix_s6[wtr_pkg::CH_RED];
	assign green     = pix_s6[wtr_pkg::CH_GREEN];
	assign blue      = pix_s6[wtr_pkg::CH_BLUE];

endmodule

FILE: src/wtr_spectrum.sv
module wtr_spectrum (
	input  logic                             clk,
	input  logic                             en,
	input  logic [wtr_pkg::WAVELENGTH_BITS-1:0] w_s1,
	output wtr_pkg::q15_vec_t                col_s2,
	output wtr_pkg::q15_t                    fac_s2
);

	localparam int WB = wtr_pkg::WAVELENGTH_BITS;
	localparam int AW = wtr_pkg::TAB_AW;

	logic [WB-1:0] off_a, off_b, off_c, off_d, off_e, off_f;
	wtr_pkg::q15_vec_t col_d;
	wtr_pkg::q15_t fac_d;

	assign off_a = w_s1 - WB'(wtr_pkg::WL_MIN);
	assign off_b = w_s1 - WB'(wtr_pkg::WL_B1);
	assign off_c = w_s1 - WB'(wtr_pkg::WL_B2);
	assign off_d = w_s1 - WB'(wtr_pkg::WL_B3);
	assign off_e = w_s1 - WB'(wtr_pkg::WL_B4);
	assign off_f = w_s1 - WB'(wtr_pkg::WL_F2 + 1);

	always_comb begin
		col_d = '0;
		fac_d = '0;
		if (w_s1 inside {[wtr_pkg::WL_MIN:wtr_pkg::WL_B1-1]}) begin
			col_d[wtr_pkg::CH_RED]  = wtr_pkg::ROM_R1[off_a[AW-1:0]];
			col_d[wtr_pkg::CH_BLUE] = wtr_pkg::ONE_Q15;
		end else if (w_s1 inside {[wtr_pkg::WL_B1:wtr_pkg::WL_B2-1]}) begin
			col_d[wtr_pkg::CH_GREEN] = wtr_pkg::ROM_G2[off_b[AW-1:0]];
			col_d[wtr_pkg::CH_BLUE]  = wtr_pkg::ONE_Q15;
		end else if (w_s1 inside {[wtr_pkg::WL_B2:wtr_pkg::WL_B3-1]}) begin
			col_d[wtr_pkg::CH_GREEN] = wtr_pkg::ONE_Q15;
			col_d[wtr_pkg::CH_BLUE]  = wtr_pkg::ROM_B3[off_c[AW-1:0]];
		end else if (w_s1 inside {[wtr_pkg::WL_B3:wtr_pkg::WL_B4-1]}) begin
			col_d[wtr_pkg::CH_RED]   = wtr_pkg::ROM_R4[off_d[AW-1:0]];
			col_d[wtr_pkg::CH_GREEN] = wtr_pkg::ONE_Q15;
		end else if (w_s1 inside {[wtr_pkg::WL_B4:wtr_pkg::WL_B5-1]}) begin
			col_d[wtr_pkg::CH_RED]   = wtr_pkg::ONE_Q15;
			col_d[wtr_pkg::CH_GREEN] = wtr_pkg::ROM_G5[off_e[AW-1:0]];
		end else if (w_s1 inside {[wtr_pkg::WL_B5:wtr_pkg::WL_MAX]}) begin
			col_d[wtr_pkg::CH_RED] = wtr_pkg::ONE_Q15;
		end

		if (w_s1 inside {[wtr_pkg::WL_MIN:wtr_pkg::WL_F1-1]})
			fac_d = wtr_pkg::ROM_FLO[off_a[AW-1:0]];
		else if (w_s1 inside {[wtr_pkg::WL_F1:wtr_pkg::WL_F2]})
			fac_d = wtr_pkg::ONE_Q15;
		else if (w_s1 inside {[wtr_pkg::WL_F2+1:wtr_pkg::WL_MAX]})
			fac_d = wtr_pkg::ROM_FHI[off_f[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s2 <= col_d;
			fac_s2 <= fac_d;
		end
	end

endmodule

FILE: src/wtr_scale.sv
module wtr_scale (
	input  logic               clk,
	input  logic               en3,
	input  logic               en4,
	input  wtr_pkg::q15_vec_t  col_s2,
	input  wtr_pkg::q15_t      fac_s2,
	output wtr_pkg::idx_vec_t  idx_s4
);

	localparam int PW = 2 * wtr_pkg::Q15_W;

	wtr_pkg::q15_vec_t p_s3;
	logic [PW-1:0] prod_a [wtr_pkg::NUM_CH];
	logic [PW-1:0] prod_b [wtr_pkg::NUM_CH];

	always_comb begin
		for (int c = 0; c < wtr_pkg::NUM_CH; c++) begin
			prod_a[c] = PW'(col_s2[c]) * PW'(fac_s2);
			prod_b[c] = PW'(p_s3[c]) * PW'(wtr_pkg::GAMMA_D);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < wtr_pkg::NUM_CH; c++) begin
			if (en3)
				p_s3[c] <= prod_a[c][15 +: wtr_pkg::Q15_W];
			if (en4)
				idx_s4[c] <= prod_b[c][15 +: wtr_pkg::ROM_AW];
		end
	end

endmodule

FILE: src/wtr_gamma.sv
module wtr_gamma (
	input  logic               clk,
	input  logic               en5,
	input  logic               en6,
	input  wtr_pkg::idx_vec_t  idx_s4,
	output wtr_pkg::pix_vec_t  pix_s6
);

	localparam int BW = wtr_pkg::BSEL_W;
	localparam int AW = wtr_pkg::BANK_AW;

	logic [7:0]    bank_s5 [wtr_pkg::NUM_CH][wtr_pkg::BANKS];
	logic [BW-1:0] bsel_s5 [wtr_pkg::NUM_CH];

	// every bank read in parallel, then pick one
	always_ff @(posedge clk) begin
		for (int c = 0; c < wtr_pkg::NUM_CH; c++) begin
			if (en5) begin
				bsel_s5[c] <= idx_s4[c][AW +: BW];
				for (int b = 0; b < wtr_pkg::BANKS; b++)
					bank_s5[c][b] <= wtr_pkg::GAMMA_ROM[{BW'(b), idx_s4[c][AW-1:0]}];
			end
			if (en6)
				pix_s6[c] <= bank_s5[c][bsel_s5[c]];
		end
	end

endmodule

FILE: src/wtr_checker.sv
module wtr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                wave_valid,
	input logic                                wave_stall,
	input logic [wtr_pkg::WAVELENGTH_BITS-1:0] wavelength_nm,
	input logic                                rgb_valid,
	input logic                                rgb_stall,
	input logic [7:0]                          red,
	input logic [7:0]                          green,
	input logic [7:0]                          blue
);

	logic acc;
	assign acc = wave_valid && !wave_stall;

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> rgb_valid && $stable(red) && $stable(green) && $stable(blue))
		else $error("stalled rgb item changed");

	// with no stall in between, the item comes out on rgb_valid; outside the span it is black
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (wavelength_nm < 380 || wavelength_nm > 780))
		##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
		|=> rgb_valid && red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("out of span item not black or late");

	// deep red band gives full red only
	a_red: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && wavelength_nm >= 645 && wavelength_nm <= 700)
		##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
		|=> rgb_valid && red == 8'd255 && green == 8'd0 && blue == 8'd0)
		else $error("deep red item wrong or late");

endmodule

bind wavelength_to_rgb_color_core wtr_checker u_wtr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.wave_valid    (wave_valid),
	.wave_stall    (wave_stall),
	.wavelength_nm (wavelength_nm),
	.rgb_valid     (rgb_valid),
	.rgb_stall     (rgb_stall),
	.red           (red),
	.green         (green),
	.blue          (blue)
);
